>>> rtl/int4_dequant_dot_product_macros.svh
// Assertion macros shared by the int4 dequant dot product modules.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef INT4_DEQUANT_DOT_PRODUCT_MACROS_SVH
`define INT4_DEQUANT_DOT_PRODUCT_MACROS_SVH

`ifndef SYNTH
`define I4DQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i4dq assertion failed");
`define I4DQ_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("i4dq forbidden condition seen");
`else
`define I4DQ_ASSERT(lbl, clk, rst, prop)
`define I4DQ_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> rtl/i4dq_pkg.sv
// Shared widths, queue entry type and defaults for the int4 dequant dot product.
// Used by every module of the block; depends on nothing.
package i4dq_pkg;

  localparam int WEIGHT_W = 8;
  localparam int NIBBLE_W = 4;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int TERM_W   = PROD_W + NIBBLE_W;
  localparam int ACC_W    = 48;

  localparam int QUEUE_DEPTH_DEF = 4;

  // One packed weight beat after the multiplies, waiting for accumulation.
  typedef struct packed {
    logic signed [TERM_W-1:0] term_low;
    logic signed [TERM_W-1:0] term_high;
    logic                     high_valid;
    logic                     last;
  } entry_t;

endpackage

>>> rtl/i4dq_front.sv
// Front end: accepts weight beats, forms scale*activation products, then the
// biased-nibble terms that it pushes into the queue. Depends on i4dq_pkg.
module i4dq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          weight_valid,
  output logic                          weight_stall,
  input  logic [i4dq_pkg::WEIGHT_W-1:0] weight_pair,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_high,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_high,
  input  logic                          high_valid,
  input  logic                          last,
  input  logic                          q_full,
  output logic                          push,
  output i4dq_pkg::entry_t              push_entry
);
  import i4dq_pkg::*;

  logic                       s_valid;
  logic signed [NIBBLE_W-1:0] s_code_low;
  logic signed [NIBBLE_W-1:0] s_code_high;
  logic signed [PROD_W-1:0]   s_prod_low;
  logic signed [PROD_W-1:0]   s_prod_high;
  logic                       s_hv;
  logic                       s_last;
  logic                       take;

  assign weight_stall = s_valid && q_full;
  assign take         = weight_valid && !weight_stall;
  assign push         = s_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!weight_stall) begin
      s_valid <= weight_valid;
    end
  end

  // A nibble minus 8 is the same nibble with its top bit flipped, read as signed.
  always_ff @(posedge clk) begin
    if (take) begin
      s_code_low  <= weight_pair[NIBBLE_W-1:0] ^ {1'b1, {(NIBBLE_W-1){1'b0}}};
      s_code_high <= weight_pair[WEIGHT_W-1:NIBBLE_W] ^ {1'b1, {(NIBBLE_W-1){1'b0}}};
      s_prod_low  <= PROD_W'(scale_low) * PROD_W'(act_low);
      s_prod_high <= PROD_W'(scale_high) * PROD_W'(act_high);
      s_hv        <= high_valid;
      s_last      <= last;
    end
  end

  always_comb begin
    push_entry.term_low   = TERM_W'(s_code_low) * TERM_W'(s_prod_low);
    push_entry.term_high  = TERM_W'(s_code_high) * TERM_W'(s_prod_high);
    push_entry.high_valid = s_hv;
    push_entry.last       = s_last;
  end

endmodule

>>> rtl/i4dq_queue.sv
// Short FIFO of term entries between the front end and the accumulator.
// Depends on i4dq_pkg and the assertion macro header.
`include "int4_dequant_dot_product_macros.svh"

module i4dq_queue #(
  parameter int DEPTH = i4dq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i4dq_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output i4dq_pkg::entry_t pop_entry
);
  import i4dq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign q_valid   = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `I4DQ_ASSERT_NEVER(a_pop_empty, clk, rst, pop && (count == '0))
  `I4DQ_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule

>>> rtl/i4dq_accum.sv
// Back end: saturating 48-bit accumulation of queued terms, one term per cycle
// unless a held result output register stalls it. Depends on i4dq_pkg and the macro header.
`include "int4_dequant_dot_product_macros.svh"

module i4dq_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  i4dq_pkg::entry_t        q_entry,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [i4dq_pkg::ACC_W-1:0] dot_sum,
  output logic                    saturated
);
  import i4dq_pkg::*;

  typedef enum logic [1:0] {
    PH_LOW  = 2'b01,
    PH_HIGH = 2'b10
  } phase_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  entry_t                  cur;
  logic                    cur_valid;
  phase_t                  phase;
  logic signed [ACC_W-1:0] acc;
  logic                    sat_seen;

  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W:0]    sum_wide;
  logic                     ovf;
  logic signed [ACC_W-1:0]  sum_sat;
  logic                     sat_next;
  logic                     final_step;
  logic                     out_free;
  logic                     advance;
  logic                     done;

  always_comb begin
    term     = (phase == PH_HIGH) ? cur.term_high : cur.term_low;
    sum_wide = (ACC_W + 1)'(acc) + (ACC_W + 1)'(term);
    ovf      = sum_wide[ACC_W] ^ sum_wide[ACC_W-1];
    if (ovf) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
    sat_next = sat_seen | ovf;
  end

  // The beat ends after its low term when the high half is skipped.
  assign final_step = cur_valid && ((phase == PH_HIGH) || !cur.high_valid);
  assign out_free   = !result_valid || !result_stall;
  assign advance    = cur_valid && !(final_step && cur.last && !out_free);
  assign done       = advance && final_step;
  assign pop        = q_valid && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      phase        <= PH_LOW;
      acc          <= '0;
      sat_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (done && cur.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (advance) begin
        if (final_step && cur.last) begin
          acc      <= '0;
          sat_seen <= 1'b0;
        end else begin
          acc      <= sum_sat;
          sat_seen <= sat_next;
        end
        phase <= final_step ? PH_LOW : PH_HIGH;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
    if (done && cur.last) begin
      dot_sum   <= sum_sat;
      saturated <= sat_next;
    end
  end

  `I4DQ_ASSERT(a_high_phase, clk, rst, (phase == PH_HIGH) |-> (cur_valid && cur.high_valid))
  `I4DQ_ASSERT(a_clear, clk, rst, (done && cur.last) |=> ((acc == '0) && !sat_seen))

endmodule

>>> rtl/int4_dequant_dot_product.sv
// Top level of the int4 dequant dot product: front end, term queue, accumulator.
// Depends on i4dq_pkg, i4dq_front, i4dq_queue and i4dq_accum.
//
// Usage: the weight channel (weight_valid / weight_stall) carries one packed
// weight byte per beat with its two scales, two activations, high_valid and
// last. The result channel (result_valid / result_stall) carries one beat,
// dot_sum and saturated, for each input beat marked last.
// Throughput: one input beat per cycle when high_valid is 0 and nothing stalls; a
// beat with high_valid 1 needs the adder for both terms and so holds the flow. The
// single 48-bit saturating adder in the accumulator takes one term per cycle, low
// term first, unless a last term waits on a stalled result. A last beat passes
// the product, queue slot, entry and result registers on its way to result_valid.
// The front end keeps taking beats while the accumulator waits, until the
// QUEUE_DEPTH entry queue and the product stage are full.
// Reset clears the accumulator, the saturation flag, the queue and all valid
// state; the block accepts beats in the first cycle after reset.
// When the receiver stalls, the result register holds its beat; terms of
// later dot products keep accumulating until the next last beat must wait.
module int4_dequant_dot_product #(
  parameter int QUEUE_DEPTH = i4dq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          weight_valid,
  output logic                          weight_stall,
  input  logic [i4dq_pkg::WEIGHT_W-1:0] weight_pair,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_high,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_high,
  input  logic                          high_valid,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [i4dq_pkg::ACC_W-1:0] dot_sum,
  output logic                          saturated
);
  import i4dq_pkg::*;

  logic   push;
  logic   q_full;
  logic   pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t pop_entry;

  i4dq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight_pair  (weight_pair),
    .scale_low    (scale_low),
    .scale_high   (scale_high),
    .act_low      (act_low),
    .act_high     (act_high),
    .high_valid   (high_valid),
    .last         (last),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  i4dq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  i4dq_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .dot_sum      (dot_sum),
    .saturated    (saturated)
  );

endmodule

>>> verif/int4_dot_product_checker.sv
// Checker for the int4 dequant dot product: watches both channels, predicts each sum
// with its own saturating accumulator and compares it with the result beats.
// Depends on i4dq_pkg for the field widths.
`timescale 1ns / 1ps

module int4_dot_product_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               weight_valid,
  input  logic                               weight_stall,
  input  logic [i4dq_pkg::WEIGHT_W-1:0]      weight_pair,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] scale_high,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_low,
  input  logic signed [i4dq_pkg::DATA_W-1:0] act_high,
  input  logic                               high_valid,
  input  logic                               last,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic signed [i4dq_pkg::ACC_W-1:0]  dot_sum,
  input  logic                               saturated,
  output int                                 mismatch_count,
  output int                                 sums_pending
);
  import i4dq_pkg::*;

  localparam longint ACC_MAX     = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN     = -ACC_MAX - 1;
  localparam longint NIBBLE_BIAS = 8;

  typedef struct {
    logic signed [ACC_W-1:0] sum;
    logic                    sat;
  } dot_result_t;

  dot_result_t expected_sums[$];
  longint      model_acc;
  logic        model_sat;

  // The code minus its bias times scale times activation is exact in 64 bits.
  function automatic longint dequant_term(input logic [NIBBLE_W-1:0] code,
                                          input logic signed [DATA_W-1:0] scale,
                                          input logic signed [DATA_W-1:0] act);
    longint w;
    w = longint'(code) - NIBBLE_BIAS;
    return w * longint'(scale) * longint'(act);
  endfunction

  task automatic accumulate(input longint t);
    longint s;
    s = model_acc + t;
    if (s > ACC_MAX) begin
      s = ACC_MAX;
      model_sat = 1'b1;
    end
    if (s < ACC_MIN) begin
      s = ACC_MIN;
      model_sat = 1'b1;
    end
    model_acc = s;
  endtask

  initial begin
    model_acc = 0;
    model_sat = 1'b0;
  end

  always @(posedge clk) begin : check_beats
    dot_result_t want;
    int          errs;
    errs = 0;
    if (rst) begin
      expected_sums.delete();
      model_acc = 0;
      model_sat = 1'b0;
    end else begin
      // A result beat is checked before this cycle's input can add a new sum.
      if (result_valid && !result_stall) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result beat, dot_sum %0d saturated %0b",
                   $time, dot_sum, saturated);
          errs++;
        end else begin
          want = expected_sums.pop_front();
          if (dot_sum !== want.sum) begin
            $display("%0t: dot_sum expected %0d got %0d", $time, want.sum, dot_sum);
            errs++;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %0b got %0b", $time, want.sat, saturated);
            errs++;
          end
        end
      end
      if (weight_valid && !weight_stall) begin
        accumulate(dequant_term(weight_pair[NIBBLE_W-1:0], scale_low, act_low));
        if (high_valid) begin
          accumulate(dequant_term(weight_pair[WEIGHT_W-1:NIBBLE_W], scale_high, act_high));
        end
        if (last) begin
          want.sum = model_acc[ACC_W-1:0];
          want.sat = model_sat;
          expected_sums.push_back(want);
          model_acc = 0;
          model_sat = 1'b0;
        end
      end
    end
    if (rst) begin
      mismatch_count <= 0;
    end else begin
      mismatch_count <= mismatch_count + errs;
    end
    sums_pending <= expected_sums.size();
  end

endmodule

>>> verif/int4_dequant_dot_product_tb.sv
// Testbench top for the int4 dequant dot product: drives directed, long and
// random weight beats with random idling, and gives the verdict.
// Depends on i4dq_pkg, int4_dequant_dot_product and int4_dot_product_checker.
`timescale 1ns / 1ps

module int4_dequant_dot_product_tb;
  import i4dq_pkg::*;

  localparam int RANDOM_BEATS = 750;
  localparam int QUIET_AFTER  = 620;
  localparam int LONG_BEATS   = 40;

  logic                     clk;
  logic                     rst;
  logic                     weight_valid;
  logic                     weight_stall;
  logic [WEIGHT_W-1:0]      weight_pair;
  logic signed [DATA_W-1:0] scale_low;
  logic signed [DATA_W-1:0] scale_high;
  logic signed [DATA_W-1:0] act_low;
  logic signed [DATA_W-1:0] act_high;
  logic                     high_valid;
  logic                     last;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [ACC_W-1:0]  dot_sum;
  logic                     saturated;
  int                       mismatch_count;
  int                       sums_pending;
  bit                       quiet;

  int4_dequant_dot_product uut (
    .clk          (clk),
    .rst          (rst),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight_pair  (weight_pair),
    .scale_low    (scale_low),
    .scale_high   (scale_high),
    .act_low      (act_low),
    .act_high     (act_high),
    .high_valid   (high_valid),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .dot_sum      (dot_sum),
    .saturated    (saturated)
  );

  int4_dot_product_checker sum_checker (
    .clk            (clk),
    .rst            (rst),
    .weight_valid   (weight_valid),
    .weight_stall   (weight_stall),
    .weight_pair    (weight_pair),
    .scale_low      (scale_low),
    .scale_high     (scale_high),
    .act_low        (act_low),
    .act_high       (act_high),
    .high_valid     (high_valid),
    .last           (last),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .dot_sum        (dot_sum),
    .saturated      (saturated),
    .mismatch_count (mismatch_count),
    .sums_pending   (sums_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver stalls come in random bursts between open stretches, some of them long.
  initial begin : result_stall_gen
    int run;
    run = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        result_stall = 1'b0;
      end else if (run > 0) begin
        run--;
      end else if (result_stall) begin
        result_stall = 1'b0;
        run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 10);
      end else begin
        result_stall = 1'b1;
        run = $urandom_range(0, 3);
      end
    end
  end

  // Extremes turn up often so that the bounds of the scale and activation fields get exercised.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [WEIGHT_W-1:0] wp,
                           input logic [DATA_W-1:0] sl, input logic [DATA_W-1:0] sh,
                           input logic [DATA_W-1:0] al, input logic [DATA_W-1:0] ah,
                           input logic hv, input logic lst);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    if (gap > 0) begin
      @(negedge clk);
      weight_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    weight_pair  = wp;
    scale_low    = sl;
    scale_high   = sh;
    act_low      = al;
    act_high     = ah;
    high_valid   = hv;
    last         = lst;
    weight_valid = 1'b1;
    do @(posedge clk); while (weight_stall);
  endtask

  // Hold the sender off until every sum in flight has come back.
  task automatic drain_sums();
    @(negedge clk);
    weight_valid = 1'b0;
    while (sums_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int len;
    bit paused;
    rst          = 1'b1;
    quiet        = 1'b0;
    weight_valid = 1'b0;
    weight_pair  = '0;
    scale_low    = '0;
    scale_high   = '0;
    act_low      = '0;
    act_high     = '0;
    high_valid   = 1'b0;
    last         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-beat sums at the field extremes, zero codes and zero scales.
    send_pair(8'h00, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b1);
    send_pair(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    send_pair(8'h0F, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    send_pair(8'h88, 16'd12345, 16'hEF1F, 16'hFFB3, 16'd999, 1'b1, 1'b1);
    send_pair(8'h80, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
    send_pair(8'h17, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
    // The skipped high half carries junk that must not reach the sum.
    send_pair(8'hF3, 16'h1000, 16'h8000, 16'h0100, 16'h8000, 1'b0, 1'b1);
    // Multi-beat sums, one of them ending on an odd tail.
    send_pair(8'h3C, 16'h1000, 16'hF000, 16'h0100, 16'h0280, 1'b1, 1'b0);
    send_pair(8'hA5, 16'h0800, 16'h2000, 16'hFF00, 16'h0040, 1'b0, 1'b0);
    send_pair(8'h71, 16'h7FFF, 16'h8001, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
    send_pair(8'hE9, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, 1'b1);
    send_pair(8'h5A, 16'h1234, 16'h4321, 16'h0ABC, 16'hF00D, 1'b1, 1'b0);
    send_pair(8'hC6, 16'h0FFF, 16'hF001, 16'h00FF, 16'hFF01, 1'b1, 1'b0);
    send_pair(8'hD2, 16'h2222, 16'h8000, 16'h3333, 16'h7FFF, 1'b0, 1'b1);
    drain_sums();

    // A long sum of the largest positive terms, pulled back on the last beat.
    for (int i = 0; i < LONG_BEATS; i++) begin
      send_pair(8'h00, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    end
    send_pair(8'h00, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
    // Same with the largest negative terms, then a small sum right after it.
    for (int i = 0; i < LONG_BEATS; i++) begin
      send_pair(8'h00, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    end
    send_pair(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    send_pair(8'h4B, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b1, 1'b1);

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_BEATS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (sent >= QUIET_AFTER) begin
          quiet = 1'b1;
        end
        send_pair(WEIGHT_W'($urandom_range(0, 255)), pick_word(), pick_word(),
                  pick_word(), pick_word(), ($urandom_range(0, 4) != 0), (i == len - 1));
        sent++;
      end
      if (!paused && sent >= RANDOM_BEATS / 2) begin
        drain_sums();
        paused = 1'b1;
      end
    end

    @(negedge clk);
    weight_valid = 1'b0;
    while (sums_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && sums_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
